// ===== hdl/xcpd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package xcpd_pkg;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POT_CODE     = 1'd1;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] POT_CODE_RST     = 8'h50;
    localparam logic [BYTE_W-1:0] MIN_FRAME_LEN    = 8'd4;

    localparam logic [BYTE_W-1:0] POS_BODY   = 8'd2;
    localparam logic [BYTE_W-1:0] POS_CMD    = 8'd2;
    localparam logic [BYTE_W-1:0] POS_FIRST  = 8'd3;
    localparam logic [BYTE_W-1:0] POS_SECOND = 8'd4;

    typedef enum logic [2:0] {
        ST_HUNT = 3'b001,
        ST_LEN  = 3'b010,
        ST_BODY = 3'b100
    } t_state;

    typedef struct packed {
        logic              bad;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] first;
        logic [BYTE_W-1:0] second;
    } t_frame;

endpackage

`default_nettype wire

// ===== hdl/xcpd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xcpd_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    input  wire [7:0]            i_rx_byte,
    input  wire [7:0]            i_start_marker,
    output logic                 o_evt_valid,
    output xcpd_pkg::t_frame     o_evt
);
    import xcpd_pkg::*;

    t_state            r_state, n_state;
    logic [BYTE_W-1:0] r_pos, n_pos;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic [BYTE_W-1:0] r_first, n_first;
    logic [BYTE_W-1:0] r_second, n_second;
    logic [BYTE_W:0]   w_pos_next;
    logic              w_last;

    assign w_pos_next = {1'b0, r_pos} + {{BYTE_W{1'b0}}, 1'b1};
    assign w_last     = (w_pos_next >= {1'b0, r_len});

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_len       = r_len;
        n_xor       = r_xor;
        n_cmd       = r_cmd;
        n_first     = r_first;
        n_second    = r_second;
        o_evt_valid = 1'b0;
        o_evt.bad    = (i_rx_byte != r_xor);
        o_evt.length = r_len;
        o_evt.cmd    = r_cmd;
        o_evt.first  = r_first;
        o_evt.second = r_second;
        if (i_valid) begin
            case (r_state)
                ST_HUNT: begin
                    if (i_rx_byte == i_start_marker) begin
                        n_xor    = i_rx_byte;
                        n_cmd    = '0;
                        n_first  = '0;
                        n_second = '0;
                        n_state  = ST_LEN;
                    end
                end
                ST_LEN: begin
                    if (i_rx_byte < MIN_FRAME_LEN) begin
                        n_state = ST_HUNT;
                    end else begin
                        n_len   = i_rx_byte;
                        n_xor   = r_xor ^ i_rx_byte;
                        n_pos   = POS_BODY;
                        n_state = ST_BODY;
                    end
                end
                ST_BODY: begin
                    if (w_last) begin
                        o_evt_valid = 1'b1;
                        n_state     = ST_HUNT;
                    end else begin
                        if (r_pos == POS_CMD) begin
                            n_cmd = i_rx_byte;
                        end
                        if (r_pos == POS_FIRST) begin
                            n_first = i_rx_byte;
                        end
                        if (r_pos == POS_SECOND) begin
                            n_second = i_rx_byte;
                        end
                        n_xor = r_xor ^ i_rx_byte;
                        n_pos = w_pos_next[BYTE_W-1:0];
                    end
                end
                default: begin
                    n_state = ST_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
        r_pos    <= n_pos;
        r_len    <= n_len;
        r_xor    <= n_xor;
        r_cmd    <= n_cmd;
        r_first  <= n_first;
        r_second <= n_second;
    end

    a_evt_in_body: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_valid |-> (r_state == ST_BODY))
        else $error("frame event outside packet body");

    a_evt_rehunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_valid |=> (r_state == ST_HUNT))
        else $error("no return to hunting after checksum byte");

endmodule

`default_nettype wire

// ===== hdl/xcpd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xcpd_fifo #(
    parameter int DEPTH = 2
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_wr,
    input  xcpd_pkg::t_frame     i_wdata,
    output logic                 o_full,
    input  wire                  i_rd,
    output xcpd_pkg::t_frame     o_rdata,
    output logic                 o_avail
);
    import xcpd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_frame        r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          w_wr, w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_rdata = r_mem[r_rptr];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && o_avail;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        if (w_wr) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (w_rd) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        n_cnt  = r_cnt;
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CW'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("frame written into full queue");

endmodule

`default_nettype wire

// ===== hdl/xcpd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module xcpd_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_evt_avail,
    input  xcpd_pkg::t_frame     i_evt,
    output logic                 o_evt_rd,
    input  wire [7:0]            i_pot_code,
    input  wire                  pop,
    output logic                 empty,
    output logic                 o_frame_status,
    output logic [7:0]           o_frame_length,
    output logic [7:0]           o_command_byte,
    output logic [7:0]           o_payload_high,
    output logic [7:0]           o_payload_low,
    output logic                 o_is_pot_reading
);
    import xcpd_pkg::*;

    logic   r_valid, n_valid;
    t_frame r_frame;
    logic   r_is_pot;
    logic   w_take;

    assign w_take   = !r_valid || pop;
    assign o_evt_rd = i_evt_avail && w_take;
    assign n_valid  = o_evt_rd || (r_valid && !pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (o_evt_rd) begin
            r_frame  <= i_evt;
            r_is_pot <= !i_evt.bad && (i_evt.cmd == i_pot_code);
        end
    end

    assign empty            = !r_valid;
    assign o_frame_status   = r_frame.bad;
    assign o_frame_length   = r_frame.length;
    assign o_command_byte   = r_frame.cmd;
    assign o_payload_high   = r_frame.first;
    assign o_payload_low    = r_frame.second;
    assign o_is_pot_reading = r_is_pot;

    a_rd_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_evt_rd |-> (!r_valid || pop))
        else $error("queue read while result stage holds a word");

endmodule

`default_nettype wire

// ===== hdl/xor_checked_packet_deframer_top.sv =====
// Channel   Ports                                   Accepted when
// input     push, full, i_rx_byte                   push && !full
// result    empty, pop, o_frame_status .. o_is_pot  pop && !empty
// config    i_cfg_we, i_cfg_idx, i_cfg_wdata        i_cfg_we
//
// One byte per cycle while full is low.
// A result goes from its checksum byte into the frame queue,
// then into the output register once that register is free.
// full rises only when the frame queue (FIFO_DEPTH words) is full.
// Reset is synchronous, active low, and restores the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module xor_checked_packet_deframer_top #(
    parameter int FIFO_DEPTH = 2
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            push,
    output logic                           full,
    input  wire [7:0]                      i_rx_byte,
    output logic                           empty,
    input  wire                            pop,
    output logic                           o_frame_status,
    output logic [7:0]                     o_frame_length,
    output logic [7:0]                     o_command_byte,
    output logic [7:0]                     o_payload_high,
    output logic [7:0]                     o_payload_low,
    output logic                           o_is_pot_reading,
    input  wire                            i_cfg_we,
    input  wire [xcpd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [7:0]                      i_cfg_wdata
);
    import xcpd_pkg::*;

    logic [BYTE_W-1:0] r_start_marker, n_start_marker;
    logic [BYTE_W-1:0] r_pot_code, n_pot_code;
    logic              w_in_fire;
    logic              w_evt_valid;
    t_frame            w_evt;
    logic              w_q_full;
    logic              w_q_avail;
    logic              w_q_rd;
    t_frame            w_q_data;

    always_comb begin
        n_start_marker = r_start_marker;
        n_pot_code     = r_pot_code;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_START_MARKER: n_start_marker = i_cfg_wdata;
                REG_POT_CODE:     n_pot_code     = i_cfg_wdata;
                default: begin
                    n_start_marker = r_start_marker;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_MARKER_RST;
            r_pot_code     <= POT_CODE_RST;
        end else begin
            r_start_marker <= n_start_marker;
            r_pot_code     <= n_pot_code;
        end
    end

    assign full      = w_q_full;
    assign w_in_fire = push && !w_q_full;

    xcpd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_in_fire),
        .i_rx_byte      (i_rx_byte),
        .i_start_marker (r_start_marker),
        .o_evt_valid    (w_evt_valid),
        .o_evt          (w_evt)
    );

    xcpd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_evt_valid),
        .i_wdata (w_evt),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_data),
        .o_avail (w_q_avail)
    );

    xcpd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_evt_avail      (w_q_avail),
        .i_evt            (w_q_data),
        .o_evt_rd         (w_q_rd),
        .i_pot_code       (r_pot_code),
        .pop              (pop),
        .empty            (empty),
        .o_frame_status   (o_frame_status),
        .o_frame_length   (o_frame_length),
        .o_command_byte   (o_command_byte),
        .o_payload_high   (o_payload_high),
        .o_payload_low    (o_payload_low),
        .o_is_pot_reading (o_is_pot_reading)
    );

endmodule

`default_nettype wire
